// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the deque core RTL.
// Depends on nothing; the checks compile to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked check, suspended while reset is held.
`define PDQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define PDQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PDQ_ASSERT(lbl, clk, rstn, prop, msg)
`define PDQ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/core/pdq_pkg.sv -----
// Shared types and constants of the priority deque with timeout eviction.
// Depends on nothing; used by the cell and the core.
`default_nettype none

package pdq_pkg;

  typedef enum logic [1:0] {
    OP_PUSH_TAIL = 2'd0,
    OP_PUSH_HEAD = 2'd1,
    OP_POP_HEAD  = 2'd2,
    OP_TIMEOUT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Register index of the timeout limit on the configuration port.
  localparam logic REG_TIMEOUT_LIMIT = 1'b0;
  localparam logic [15:0] TIMEOUT_LIMIT_RESET = 16'd2;

  typedef struct packed {
    op_t         opcode;
    logic [15:0] entry_id;
    logic [15:0] arrival_time;
    logic [15:0] now_time;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic        removed_valid;
    logic [15:0] removed_id;
    logic [15:0] removed_arrival;
    logic [4:0]  occupancy;
  } out_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic fire;
    op_t  op;
    logic full;
    logic empty;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/pdq_cell.sv -----
// One slot of the deque: holds a tag and an arrival time and moves them to
// its neighbors. Depends on pdq_pkg.
`default_nettype none

module pdq_cell
  import pdq_pkg::*;
#(
  parameter int TW = 16
) (
  input  wire logic          clk,
  input  wire cell_cmd_t     cmd,
  input  wire logic          valid,
  input  wire logic          is_tail,
  input  wire logic [15:0]   limit,
  input  wire logic [TW-1:0] now,
  input  wire logic [15:0]   new_tag,
  input  wire logic [TW-1:0] new_ts,
  input  wire logic [15:0]   prev_tag,
  input  wire logic [TW-1:0] prev_ts,
  input  wire logic [15:0]   next_tag,
  input  wire logic [TW-1:0] next_ts,
  input  wire logic          hit_in,
  output logic               hit_out,
  output logic               first,
  output logic [15:0]        tag,
  output logic [TW-1:0]      ts
);

  localparam int CMPW = (TW > 16) ? TW : 16;

  logic [15:0]   tag_r, tag_nxt;
  logic [TW-1:0] ts_r, ts_nxt;
  logic [TW-1:0] age;
  logic          expired;

  assign age     = now - ts_r;
  assign expired = valid & (CMPW'(age) > CMPW'(limit));
  assign hit_out = hit_in | expired;
  assign first   = expired & ~hit_in;
  assign tag     = tag_r;
  assign ts      = ts_r;

  always_comb begin
    tag_nxt = tag_r;
    ts_nxt  = ts_r;
    if (cmd.fire) begin
      case (cmd.op)
        OP_PUSH_TAIL: begin
          if (!cmd.full && is_tail) begin
            tag_nxt = new_tag;
            ts_nxt  = new_ts;
          end
        end
        OP_PUSH_HEAD: begin
          if (!cmd.full) begin
            tag_nxt = prev_tag;
            ts_nxt  = prev_ts;
          end
        end
        OP_POP_HEAD: begin
          if (!cmd.empty) begin
            tag_nxt = next_tag;
            ts_nxt  = next_ts;
          end
        end
        OP_TIMEOUT: begin
          // Slots at and behind the first expired entry close the gap.
          if (hit_out) begin
            tag_nxt = next_tag;
            ts_nxt  = next_ts;
          end
        end
        default: begin
          tag_nxt = tag_r;
          ts_nxt  = ts_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
    ts_r  <= ts_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/priority_deque_with_timeout_core.sv -----
// Top level of the priority deque with timeout eviction: a row of pdq_cell
// slots, the occupancy count, the timeout register and the result register.
// Depends on pdq_pkg, pdq_cell and assert_macros.svh.
//
//   Channel   Direction  Handshake          Payload
//   in_       input      in_valid/in_stall   in_data  (in_t)
//   out_      output     out_valid/out_stall out_data (out_t)
//   config    input      APB psel/penable    paddr, pwdata, prdata
//
// While the input is not stalled, one item is taken per cycle and its result
// appears in the result register on the next cycle. The row of cells does the
// whole update as the item is taken: each slot computes its age and expiry, and
// the first-expired mark ripples down so the slots behind it shift up together.
// Reset clears the occupancy count, the result valid and the timeout limit
// (to 2); the slot contents are not cleared and need no sweep.
// The input is stalled only while a result is held and the output is stalled.
`default_nettype none
`include "assert_macros.svh"

module priority_deque_with_timeout_core
  import pdq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int TIME_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int TW    = TIME_WIDTH;

  // Configuration register. The register index is the word address.
  logic [15:0] limit_r, limit_nxt;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    limit_nxt = limit_r;
    if (cfg_wr && (paddr[2] == REG_TIMEOUT_LIMIT)) begin
      limit_nxt = pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_TIMEOUT_LIMIT) ? {16'd0, limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= TIMEOUT_LIMIT_RESET;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  // Handshake. A transfer on the input is taken whenever the result register
  // is free or is being emptied in the same cycle.
  logic accept;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Command for the row of cells.
  logic [CNT_W-1:0] count_r, count_nxt;
  cell_cmd_t        cmd;
  logic [TW-1:0]    now_t;
  logic [TW-1:0]    new_ts;

  assign cmd.fire  = accept;
  assign cmd.op    = in_data.opcode;
  assign cmd.full  = (count_r == CNT_W'(DEPTH));
  assign cmd.empty = (count_r == '0);
  assign now_t     = TW'(in_data.now_time);
  assign new_ts    = TW'(in_data.arrival_time);

  // The row of cells. Slot 0 is the head; the head takes a pushed-at-head
  // entry from its upstream side and the last slot reloads itself on a shift up.
  logic [15:0]   tag_a [DEPTH];
  logic [TW-1:0] ts_a  [DEPTH];
  logic [DEPTH:0] hit_chain;
  logic [DEPTH-1:0] first_v;

  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [15:0]   prev_tag, next_tag;
    logic [TW-1:0] prev_ts, next_ts;

    if (i == 0) begin : g_head
      assign prev_tag = in_data.entry_id;
      assign prev_ts  = new_ts;
    end else begin : g_body
      assign prev_tag = tag_a[i-1];
      assign prev_ts  = ts_a[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_tag = tag_a[i];
      assign next_ts  = ts_a[i];
    end else begin : g_mid
      assign next_tag = tag_a[i+1];
      assign next_ts  = ts_a[i+1];
    end

    pdq_cell #(
      .TW (TW)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .valid    (CNT_W'(i) < count_r),
      .is_tail  (CNT_W'(i) == count_r),
      .limit    (limit_r),
      .now      (now_t),
      .new_tag  (in_data.entry_id),
      .new_ts   (new_ts),
      .prev_tag (prev_tag),
      .prev_ts  (prev_ts),
      .next_tag (next_tag),
      .next_ts  (next_ts),
      .hit_in   (hit_chain[i]),
      .hit_out  (hit_chain[i+1]),
      .first    (first_v[i]),
      .tag      (tag_a[i]),
      .ts       (ts_a[i])
    );
  end

  // The first expired slot is marked one-hot, so its contents are picked out
  // with an AND-OR select.
  logic [15:0]   exp_tag;
  logic [TW-1:0] exp_ts;

  always_comb begin
    exp_tag = '0;
    exp_ts  = '0;
    for (int k = 0; k < DEPTH; k++) begin
      exp_tag = exp_tag | (tag_a[k] & {16{first_v[k]}});
      exp_ts  = exp_ts  | (ts_a[k]  & {TW{first_v[k]}});
    end
  end

  // Occupancy and the result of the item.
  always_comb begin
    count_nxt                    = count_r;
    out_data_nxt.status          = ST_OK;
    out_data_nxt.removed_valid   = 1'b0;
    out_data_nxt.removed_id      = '0;
    out_data_nxt.removed_arrival = '0;
    case (in_data.opcode)
      OP_PUSH_TAIL, OP_PUSH_HEAD: begin
        if (cmd.full) begin
          out_data_nxt.status = ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      OP_POP_HEAD: begin
        if (cmd.empty) begin
          out_data_nxt.status = ST_EMPTY;
        end else begin
          count_nxt                    = count_r - 1'b1;
          out_data_nxt.removed_valid   = 1'b1;
          out_data_nxt.removed_id      = tag_a[0];
          out_data_nxt.removed_arrival = 16'(ts_a[0]);
        end
      end
      OP_TIMEOUT: begin
        if (hit_chain[DEPTH]) begin
          count_nxt                    = count_r - 1'b1;
          out_data_nxt.removed_valid   = 1'b1;
          out_data_nxt.removed_id      = exp_tag;
          out_data_nxt.removed_arrival = 16'(exp_ts);
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    out_data_nxt.occupancy = 5'(count_nxt);
    out_valid_nxt          = accept | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Checks on the core's own bookkeeping.
  `PDQ_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(DEPTH), "occupancy above depth")
  `PDQ_ASSERT(a_first_onehot, clk, rst_n, $onehot0(first_v), "more than one first expired slot")
  `PDQ_ASSERT(a_removed_ok, clk, rst_n, (out_valid_r && out_data_r.removed_valid) |-> (out_data_r.status == ST_OK), "removal reported with error status")
  `PDQ_ASSERT(a_empty_pop, clk, rst_n, (accept && cmd.empty && (in_data.opcode == OP_POP_HEAD)) |=> (count_r == '0), "pop on empty changed occupancy")
  `PDQ_ASSERT(a_hold_idle, clk, rst_n, (!accept && !cfg_wr) |=> ($stable(count_r) && $stable(limit_r)), "state changed without a transfer")

endmodule

`default_nettype wire

// ----- sim/priority_deque_with_timeout_core_test.sv -----
// Self-checking testbench for priority_deque_with_timeout_core: directed and random
// traffic on the item channel, timeout-limit writes over the APB port, results checked.
// Depends on pdq_pkg and the core RTL only.

module priority_deque_with_timeout_core_test
  import pdq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  // Cycles without any transfer before the run is declared hung.
  localparam int HANG_LIMIT = 2000;
  localparam logic [2:0] LIMIT_ADDR = 3'(4 * REG_TIMEOUT_LIMIT);

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  priority_deque_with_timeout_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Our own copy of the deque: slot 0 is the head, only slots below held_count
  // are ever meaningful.
  logic [15:0] slot_tags [DEPTH];
  logic [15:0] slot_times[DEPTH];
  int          held_count;
  logic [15:0] timeout_limit_model;

  // Results predicted at each accepted item, oldest first.
  out_t expected_results[$];

  int failures;
  int transfers_seen;
  int items_accepted;
  int results_checked;
  int removals_seen;
  int full_drops_seen;
  int empty_pops_seen;

  // Percent chance per cycle that the sender holds back or the receiver stalls.
  int sender_idle_pct;
  int receiver_idle_pct;

  // Stimulus time base for well-formed traffic; pushes are stamped a little
  // behind it and timeout checks use it as the current time.
  logic [15:0] stim_clock;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Apply one item to the model deque and return the result it must produce.
  // Pop and timeout share the removal path: find the slot, report it, and
  // close the gap by moving everything behind it one place toward the head.
  function automatic out_t deque_step(in_t item);
    out_t        res;
    int          victim;
    int          i;
    logic [15:0] age;
    res = '0;
    res.status = ST_OK;
    victim = -1;
    case (item.opcode)
      OP_PUSH_TAIL, OP_PUSH_HEAD: begin
        if (held_count >= DEPTH) begin
          res.status = ST_FULL;
        end else if (item.opcode == OP_PUSH_TAIL) begin
          slot_tags[held_count] = item.entry_id;
          slot_times[held_count] = item.arrival_time;
          held_count++;
        end else begin
          for (i = held_count; i > 0; i--) begin
            slot_tags[i] = slot_tags[i - 1];
            slot_times[i] = slot_times[i - 1];
          end
          slot_tags[0] = item.entry_id;
          slot_times[0] = item.arrival_time;
          held_count++;
        end
      end
      OP_POP_HEAD: begin
        if (held_count == 0) res.status = ST_EMPTY;
        else victim = 0;
      end
      default: begin
        // The age wraps at 16 bits, so an entry stamped just before the time
        // base rolls over is still young right after it.
        for (i = 0; i < held_count && victim < 0; i++) begin
          age = item.now_time - slot_times[i];
          if (age > timeout_limit_model) victim = i;
        end
      end
    endcase
    if (victim >= 0) begin
      res.removed_valid = 1'b1;
      res.removed_id = slot_tags[victim];
      res.removed_arrival = slot_times[victim];
      for (i = victim; i + 1 < held_count; i++) begin
        slot_tags[i] = slot_tags[i + 1];
        slot_times[i] = slot_times[i + 1];
      end
      held_count--;
    end
    res.occupancy = 5'(held_count);
    return res;
  endfunction

  task automatic check_result(out_t got, out_t want);
    if (got.status !== want.status) begin
      $error("status expected %0d got %0d", want.status, got.status);
      failures++;
    end
    if (got.removed_valid !== want.removed_valid) begin
      $error("removed_valid expected %0b got %0b", want.removed_valid, got.removed_valid);
      failures++;
    end
    if (got.removed_id !== want.removed_id) begin
      $error("removed_id expected %h got %h", want.removed_id, got.removed_id);
      failures++;
    end
    if (got.removed_arrival !== want.removed_arrival) begin
      $error("removed_arrival expected %h got %h", want.removed_arrival, got.removed_arrival);
      failures++;
    end
    if (got.occupancy !== want.occupancy) begin
      $error("occupancy expected %0d got %0d", want.occupancy, got.occupancy);
      failures++;
    end
  endtask

  // Both channels are observed at the rising edge, before the design's
  // registers move. A result is checked before the item of the same edge is
  // predicted, since that result always belongs to an earlier item.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        transfers_seen++;
        results_checked++;
        if (expected_results.size() == 0) begin
          $error("result transfer with no item outstanding");
          failures++;
        end else begin
          check_result(out_data, expected_results.pop_front());
        end
        if (out_data.removed_valid) removals_seen++;
        if (out_data.status == ST_FULL) full_drops_seen++;
        if (out_data.status == ST_EMPTY) empty_pops_seen++;
      end
      if (in_valid && !in_stall) begin
        transfers_seen++;
        items_accepted++;
        expected_results.push_back(deque_step(in_data));
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  // Hang detection: any transfer on either channel or the APB port resets it.
  initial begin
    int last_seen;
    int quiet_cycles;
    last_seen = 0;
    quiet_cycles = 0;
    while (quiet_cycles < HANG_LIMIT) begin
      @(posedge clk);
      if (transfers_seen != last_seen) quiet_cycles = 0;
      else quiet_cycles++;
      last_seen = transfers_seen;
    end
    $display("Timeout: no transfer for %0d cycles", HANG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  function automatic in_t make_item(op_t op, logic [15:0] id, logic [15:0] arrival,
                                    logic [15:0] now);
    in_t item;
    item.opcode = op;
    item.entry_id = id;
    item.arrival_time = arrival;
    item.now_time = now;
    return item;
  endfunction

  // Offer one item and hold it until it is taken. The valid line stays high
  // across back-to-back transfers; within this task it drops only during a drawn gap.
  task automatic send_item(in_t item);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering items and wait until every outstanding result is back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // One item gives exactly one result, so nothing is in flight now; a
    // further wait at the clock edge covers the result register.
    @(posedge clk);
  endtask

  task automatic apb_access(logic write, logic [2:0] addr, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    transfers_seen++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic read_limit_check(logic [15:0] want);
    logic [31:0] rdata;
    apb_access(1'b0, LIMIT_ADDR, 32'd0, rdata);
    if (rdata[15:0] !== want) begin
      $error("timeout_limit expected %h got %h", want, rdata[15:0]);
      failures++;
    end
  endtask

  // Change the limit only with the deque idle, then read it back.
  task automatic set_timeout_limit(logic [15:0] value);
    logic [31:0] rdata;
    wait_drained();
    apb_access(1'b1, LIMIT_ADDR, {16'd0, value}, rdata);
    timeout_limit_model = value;
    read_limit_check(value);
  endtask

  task automatic test_reset_limit();
    read_limit_check(TIMEOUT_LIMIT_RESET);
  endtask

  // Hand-picked sequence with the reset limit of 2: empty pop and empty check,
  // field extremes, an age that wraps past zero, a fill to full with pushes
  // that are then dropped at both ends, and an eviction from the middle.
  task automatic test_directed_ops();
    int i;
    send_item(make_item(OP_POP_HEAD, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(make_item(OP_TIMEOUT, 16'h0000, 16'h0000, 16'hFFFF));
    send_item(make_item(OP_PUSH_TAIL, 16'hFFFF, 16'h0000, 16'hFFFF));
    send_item(make_item(OP_PUSH_HEAD, 16'h0000, 16'hFFFF, 16'h0000));
    // Ages are 2 and 1 here, neither above the limit.
    send_item(make_item(OP_TIMEOUT, 16'hFFFF, 16'hFFFF, 16'h0001));
    // The head has now aged 3 across the wrap and goes.
    send_item(make_item(OP_TIMEOUT, 16'h5A5A, 16'hA5A5, 16'h0002));
    for (i = 0; i < 15; i++) begin
      send_item(make_item(i[0] ? OP_PUSH_HEAD : OP_PUSH_TAIL, 16'h1000 + 16'(i) ^ 16'hA5A5,
                          (i == 7) ? 16'h8000 : 16'h0002, 16'(i)));
    end
    send_item(make_item(OP_PUSH_TAIL, 16'hBEEF, 16'h0002, 16'h0000));
    send_item(make_item(OP_PUSH_HEAD, 16'hCAFE, 16'h0002, 16'h0000));
    // Only the entry stamped far in the past has expired; it sits mid-queue.
    send_item(make_item(OP_TIMEOUT, 16'h0000, 16'h0000, 16'h0002));
    send_item(make_item(OP_POP_HEAD, 16'h0000, 16'h0000, 16'h0000));
  endtask

  // Random traffic. Most items are well formed: pushes stamped a little behind
  // the time base and checks at the time base, with the spread scaled to the
  // current limit so that evictions and survivors both happen. The opcode mix
  // leans on the occupancy to visit both empty and full. One item in ten is
  // pure noise on every field.
  task automatic run_random_items(int count);
    in_t item;
    int  spread;
    int  roll;
    int  push_pct;
    int  k;
    op_t op;
    spread = (timeout_limit_model >= 16'h4000) ? 65535 : 2 * timeout_limit_model + 3;
    for (k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      push_pct = (held_count <= 2) ? 75 : (held_count >= 14) ? 35 : 50;
      if (roll < 10) begin
        item.opcode = op_t'($urandom_range(3));
        item.entry_id = 16'($urandom);
        item.arrival_time = 16'($urandom);
        item.now_time = 16'($urandom);
      end else begin
        if ($urandom_range(99) < push_pct) op = $urandom_range(1) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
        else op = $urandom_range(1) ? OP_POP_HEAD : OP_TIMEOUT;
        item.opcode = op;
        item.entry_id = 16'($urandom);
        item.arrival_time = stim_clock - 16'($urandom_range(spread / 4));
        item.now_time = (op == OP_TIMEOUT) ? stim_clock : 16'($urandom);
      end
      send_item(item);
      stim_clock += 16'($urandom_range(spread / 8 + 1));
    end
  endtask

  // One idling profile, split between two limits. The limit change in the
  // middle makes the sender wait until every result is back.
  task automatic test_random_traffic(int send_pct, int recv_pct, logic [15:0] first_limit,
                                     logic [15:0] second_limit, int count);
    sender_idle_pct = send_pct;
    receiver_idle_pct = recv_pct;
    set_timeout_limit(first_limit);
    run_random_items(count / 2);
    set_timeout_limit(second_limit);
    run_random_items(count - count / 2);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    held_count = 0;
    timeout_limit_model = TIMEOUT_LIMIT_RESET;
    failures = 0;
    transfers_seen = 0;
    items_accepted = 0;
    results_checked = 0;
    removals_seen = 0;
    full_drops_seen = 0;
    empty_pops_seen = 0;
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    stim_clock = 16'($urandom);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_limit();
    test_directed_ops();
    test_random_traffic(9, 65, 16'h0000, 16'hFFFF, 400);
    test_random_traffic(65, 9, 16'($urandom_range(1, 20)), 16'd2, 400);
    test_random_traffic(0, 0, 16'($urandom), 16'($urandom_range(3, 40)), 400);

    wait_drained();
    // Keep watching for any stray result before the final check.
    repeat (4) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      failures++;
    end

    $display("Checked %0d results for %0d items across seven timeout limit settings and three",
             results_checked, items_accepted);
    $display("stall profiles: %0d removals, %0d dropped pushes, %0d pops on empty.",
             removals_seen, full_drops_seen, empty_pops_seen);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- priority_deque_with_timeout_core.f -----
+incdir+rtl/core
rtl/core/pdq_pkg.sv
rtl/core/pdq_cell.sv
rtl/core/priority_deque_with_timeout_core.sv
sim/priority_deque_with_timeout_core_test.sv
